>>> sv/srcs_pkg.sv
// ---------------------------------------------------------------------------
// srcs_pkg
// Shared constants and types for the sensor reading convert and store block.
// ---------------------------------------------------------------------------
package srcs_pkg;

  localparam int unsigned SENSOR_TYPES     = 3;
  localparam int unsigned SENSORS_PER_TYPE = 3;
  localparam int unsigned STORE_DEPTH      = SENSOR_TYPES * SENSORS_PER_TYPE;
  localparam int unsigned SLOT_W           = $clog2(STORE_DEPTH);

  localparam logic [15:0] STALE_RESET = 16'd5000;

  // operation codes
  localparam logic [1:0] OP_RATIO  = 2'd0;
  localparam logic [1:0] OP_THERMO = 2'd1;
  localparam logic [1:0] OP_PT     = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam int unsigned DIV_W   = 16;
  localparam int unsigned HORN_W  = 40;
  localparam int unsigned HORN_N  = 8;

  // ceil(2^38 / 13107), exact floor division for products below 2^24
  localparam logic [24:0] SCALE_RECIP = 25'd20971841;

  // powers 7 down to 0, scaled by 32768^k, Q16
  localparam logic signed [HORN_W-1:0] HORNER_Q16 [HORN_N] = '{
    -40'sd22499837074,
     40'sd57682008702,
    -40'sd53012127049,
     40'sd18770416357,
      -40'sd376311017,
      -40'sd988266053,
     40'sd3275143053,
        -40'sd147457
  };

  typedef struct packed {
    logic             start;
    logic [2*DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

endpackage

>>> sv/srcs_in_if.sv
// ---------------------------------------------------------------------------
// srcs_in_if
// Input item channel: operation, sensor id, sample, reference and tick.
// ---------------------------------------------------------------------------
interface srcs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [4:0]  sensor_id;
  logic [15:0] raw_sample;
  logic [15:0] reference_level;
  logic [31:0] now_ticks;

  modport source (output valid, opcode, sensor_id, raw_sample, reference_level, now_ticks,
                  input ready);
  modport sink   (input valid, opcode, sensor_id, raw_sample, reference_level, now_ticks,
                  output ready);
endinterface

>>> sv/srcs_out_if.sv
// ---------------------------------------------------------------------------
// srcs_out_if
// Result channel: stored reading and freshness flag.
// ---------------------------------------------------------------------------
interface srcs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] reading;
  logic               fresh;

  modport source (output valid, reading, fresh, input ready);
  modport sink   (input valid, reading, fresh, output ready);
endinterface

>>> sv/srcs_div.sv
// ---------------------------------------------------------------------------
// srcs_div
// Restoring divider, one quotient bit per cycle; needs num < den * 2^16.
// ---------------------------------------------------------------------------
module srcs_div
  import srcs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  output logic [DIV_W-1:0] quo_o,
  output logic             done_o
);

  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] sh_q, sh_d;
  logic [4:0]       cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [DIV_W:0]   trial;
  logic             ge;

  always_comb begin
    trial  = {rem_q, sh_q[DIV_W-1]};
    ge     = trial >= {1'b0, req_i.den};
    rem_d  = rem_q;
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d = req_i.num[2*DIV_W-1:DIV_W];
      sh_d  = req_i.num[DIV_W-1:0];
      cnt_d = 5'(DIV_W);
    end else if (cnt_q != 5'd0) begin
      rem_d  = ge ? DIV_W'(trial - {1'b0, req_i.den}) : trial[DIV_W-1:0];
      sh_d   = {sh_q[DIV_W-2:0], ge};
      cnt_d  = cnt_q - 5'd1;
      done_d = cnt_q == 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
  end

  assign quo_o  = sh_q;
  assign done_o = done_q;

endmodule

>>> sv/sensor_reading_convert_store_core.sv
// ---------------------------------------------------------------------------
// sensor_reading_convert_store_core
// Converts sensor samples and keeps the latest value and tick per sensor.
// ---------------------------------------------------------------------------
// One item is worked at a time. A read goes through transfer, memory read,
// then freshness check and result load; a bad id skips the memory read, and
// a PT pressure write goes from transfer to the store write. A ratiometric
// write makes one pass through the bit-serial divider when the sample lies
// inside the window; the scale to 0..1000 is a reciprocal multiply. A
// thermocouple write runs seven Horner steps, each a low product, high
// product, sum and rounding through the split 40x16 multiplier, then final
// rounding and the store write. The store is a 9-entry memory with
// registered read and per-entry valid flags, so it reads as zero right after
// reset with no clearing pass. The next item is taken while a read result
// still waits; a later read holds in its freshness check until that result is taken.
module sensor_reading_convert_store_core
  import srcs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  srcs_in_if.sink     sample_i,
  srcs_out_if.source  result_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_RDCHK, S_RLIM, S_RCMP, S_RDIV1, S_RSCL,
    S_TLO, S_THI, S_TSUM, S_TRND, S_TFIN, S_WR
  } state_e;

  state_e state_q;
  logic [15:0] limit_q;

  logic [1:0]        op_q;
  logic [SLOT_W-1:0] slot_q;
  logic [15:0]       raw_q, ref_q, lo_q, hi_q, m_q;
  logic [31:0]       now_q, value_q;
  logic signed [HORN_W-1:0] y_q;
  logic [2:0]        k_q;
  logic signed [36:0] plo_q;
  logic signed [35:0] phi_q;
  logic signed [56:0] prod_q;

  logic [63:0] mem_q [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] vld_q;
  logic [63:0] rd_q;
  logic        slot_ok_q;

  logic              out_valid_q, out_fresh_q;
  logic [31:0]       out_reading_q;

  // id decode
  logic [1:0]        id_type;
  logic [2:0]        id_sub;
  logic              id_ok;
  logic [SLOT_W-1:0] id_slot;
  always_comb begin
    id_type = sample_i.sensor_id[4:3];
    id_sub  = sample_i.sensor_id[2:0];
    id_ok   = (32'(id_type) < SENSOR_TYPES) && (32'(id_sub) < SENSORS_PER_TYPE);
    id_slot = SLOT_W'(32'(id_type) * SENSORS_PER_TYPE + 32'(id_sub));
  end

  assign sample_i.ready = state_q == S_IDLE;
  logic in_xfer;
  assign in_xfer = sample_i.valid && sample_i.ready;

  logic load_result;
  assign load_result = (state_q == S_RDCHK) && (!out_valid_q || result_o.ready);

  // divider
  div_req_t         div_req;
  logic [DIV_W-1:0] div_quo;
  logic             div_done;
  logic [15:0]      diff;
  always_comb begin
    diff          = raw_q - lo_q;
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = hi_q - lo_q;
    if (state_q == S_RCMP) begin
      div_req.start = (raw_q > lo_q) && (raw_q < hi_q);
      div_req.num   = {diff, 16'd0} - {16'd0, diff};
    end
  end

  srcs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .quo_o  (div_quo),
    .done_o (div_done)
  );

  // reference window, divide by ten through reciprocals
  logic [32:0] lo_prod;
  logic [19:0] ref9;
  logic [39:0] hi_prod;
  always_comb begin
    lo_prod = ref_q * 17'd52429;
    ref9    = {1'b0, ref_q, 3'd0} + {4'd0, ref_q};
    hi_prod = ref9 * 20'hCCCCD;
  end

  // m * 200 / 13107 through a reciprocal multiply
  logic [23:0] m200;
  logic [48:0] scl_prod;
  always_comb begin
    m200     = 24'({m_q, 7'd0}) + 24'({m_q, 6'd0}) + 24'({m_q, 3'd0});
    scl_prod = m200 * SCALE_RECIP;
  end

  // horner arithmetic
  logic signed [15:0] x_s;
  logic signed [56:0] radj;
  logic signed [HORN_W-1:0] yadj;
  assign x_s  = $signed(raw_q);
  assign radj = prod_q + 57'sd16384 - $signed({56'd0, prod_q[56]});
  assign yadj = y_q + 40'sd32768 - $signed({39'd0, y_q[HORN_W-1]});

  // pt pressure
  logic signed [17:0] pt_sum, pt_adj;
  assign pt_sum = 18'(x_s) + 18'sd16000;
  assign pt_adj = pt_sum + (pt_sum[17] ? 18'sd31 : 18'sd0);

  logic [31:0] age;
  assign age = now_q - rd_q[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      limit_q     <= STALE_RESET;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (load_result) out_valid_q <= 1'b1;
      else if (result_o.ready) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            op_q   <= sample_i.opcode;
            slot_q <= id_slot;
            raw_q  <= sample_i.raw_sample;
            ref_q  <= sample_i.reference_level;
            now_q  <= sample_i.now_ticks;
            y_q    <= HORNER_Q16[0];
            k_q    <= 3'd1;
            if (sample_i.opcode == OP_READ) begin
              state_q <= id_ok ? S_RD : S_RDCHK;
            end else if (!id_ok) begin
              state_q <= S_IDLE;
            end else begin
              case (sample_i.opcode)
                OP_RATIO:  state_q <= S_RLIM;
                OP_THERMO: state_q <= S_TLO;
                default:   state_q <= S_WR;
              endcase
            end
          end
        end
        S_RD: state_q <= S_RDCHK;
        S_RDCHK: begin
          if (load_result) begin
            if (op_q == OP_READ && slot_ok_q && age <= {16'd0, limit_q}) begin
              out_reading_q <= rd_q[63:32];
              out_fresh_q   <= 1'b1;
            end else begin
              out_reading_q <= 32'hFFFF_FFFF;
              out_fresh_q   <= 1'b0;
            end
            state_q <= S_IDLE;
          end
        end
        S_RLIM: begin
          lo_q    <= 16'(lo_prod[32:19]);
          hi_q    <= hi_prod[38:23];
          state_q <= S_RCMP;
        end
        S_RCMP: begin
          if (raw_q <= lo_q) begin
            m_q     <= 16'd0;
            state_q <= S_RSCL;
          end else if (raw_q >= hi_q) begin
            m_q     <= 16'hFFFF;
            state_q <= S_RSCL;
          end else begin
            state_q <= S_RDIV1;
          end
        end
        S_RDIV1: begin
          if (div_done) begin
            m_q     <= div_quo;
            state_q <= S_RSCL;
          end
        end
        S_RSCL: begin
          value_q <= {22'd0, scl_prod[47:38]};
          state_q <= S_WR;
        end
        S_TLO: begin
          plo_q   <= $signed({1'b0, y_q[19:0]}) * x_s;
          state_q <= S_THI;
        end
        S_THI: begin
          phi_q   <= $signed(y_q[39:20]) * x_s;
          state_q <= S_TSUM;
        end
        S_TSUM: begin
          prod_q  <= ($signed({{1{phi_q[35]}}, phi_q, 20'd0})) + 57'(plo_q);
          state_q <= S_TRND;
        end
        S_TRND: begin
          y_q     <= radj[54:15] + HORNER_Q16[k_q];
          k_q     <= k_q + 3'd1;
          state_q <= (k_q == 3'(HORN_N - 1)) ? S_TFIN : S_TLO;
        end
        S_TFIN: begin
          value_q <= {{8{yadj[HORN_W-1]}}, yadj[HORN_W-1:16]};
          state_q <= S_WR;
        end
        S_WR: begin
          vld_q[slot_q] <= 1'b1;
          state_q       <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // id validity for the read in flight
  always_ff @(posedge clk_i) begin
    if (in_xfer) slot_ok_q <= id_ok;
  end

  // store memory, registered read
  logic [31:0] wr_value;
  assign wr_value = (op_q == OP_PT) ? {{19{pt_adj[17]}}, pt_adj[17:5]} : value_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_WR) mem_q[slot_q] <= {wr_value, now_q};
    rd_q <= vld_q[slot_q] ? mem_q[slot_q] : 64'd0;
  end

  assign result_o.valid   = out_valid_q;
  assign result_o.reading = out_reading_q;
  assign result_o.fresh   = out_fresh_q;

endmodule
